>>> sv/ptfc_pkg.sv
// Shared types and codes for the page table and frame claim block
`timescale 1ns / 1ps
package ptfc_pkg;
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_ACCESS = 2'd1;
    localparam logic [1:0] REQ_CLAIM = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam logic [2:0] ST_DONE = 3'd0;
    localparam logic [2:0] ST_HIT = 3'd1;
    localparam logic [2:0] ST_FAULT = 3'd2;
    localparam logic [2:0] ST_DENIED = 3'd3;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd4;
    localparam logic [2:0] ST_BAD_ARG = 3'd5;

    localparam logic [1:0] CFG_PAGE_SHIFT = 2'd0;
    localparam logic [1:0] CFG_PROCS = 2'd1;
    localparam logic [1:0] CFG_PAGES = 2'd2;

    // table sizes
    localparam int PROC_CNT = 4;
    localparam int PAGE_CNT = 64;
    localparam int FRAME_CNT = 16;

    // entry flag bit positions
    localparam int FL_ALLOC_B = 3;
    localparam int FL_VALID_B = 4;
    localparam int FL_REF_B = 5;
    localparam int FL_DIRTY_B = 6;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input beat
        logic read;     // read entry, frame tables
        logic update;   // apply writes, form result
    } ptfc_cmd_t;

    typedef struct packed {
        logic busy_clear; // reserved for status, always 0
    } ptfc_sts_t;
endpackage

>>> sv/ptfc_ctrl.sv
// Controller: sequences capture, table read and update for one request
`timescale 1ns / 1ps
module ptfc_ctrl
    import ptfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output ptfc_cmd_t cmd
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_UPD  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // the result register holds while the next beat is taken in
    assign in_stall = !(state_reg == S_IDLE || (state_reg == S_OUT && !out_stall));
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.load = in_valid && !in_stall;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_READ;
            S_READ:
            begin
                cmd.read = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
                if (!out_stall)
                    state_next = in_valid ? S_READ : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_load_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_READ) else $error("load not followed by read");
    a_read_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> state_reg == S_UPD) else $error("read not followed by update");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("result dropped");
endmodule

>>> sv/ptfc_datapath.sv
// Datapath: page tables, frame table, counters and result register
`timescale 1ns / 1ps
module ptfc_datapath
    import ptfc_pkg::*;
#(
    parameter int ADDR_BITS = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptfc_cmd_t             cmd,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [6:0]            cfg_data,
    input  logic [1:0]            req_type,
    input  logic [1:0]            pid,
    input  logic [5:0]            page_index,
    input  logic [ADDR_BITS-1:0]  vaddr,
    input  logic [2:0]            access_flags,
    input  logic [3:0]            frame_index,
    output logic [2:0]            status,
    output logic [3:0]            frame_number,
    output logic                  evicted,
    output logic [1:0]            evicted_pid,
    output logic [5:0]            victim_page,
    output logic                  evicted_dirty,
    output logic [COUNT_BITS-1:0] reference_total,
    output logic [COUNT_BITS-1:0] fault_total,
    output logic [COUNT_BITS-1:0] discard_total,
    output logic [COUNT_BITS-1:0] write_total,
    output logic [4:0]            free_frames,
    output logic [COUNT_BITS-1:0] frame_stamp
);
    localparam int PB = (PROC_CNT > 1) ? $clog2(PROC_CNT) : 1;
    localparam int GB = $clog2(PAGE_CNT);
    localparam int FB = $clog2(FRAME_CNT);
    localparam int EB = PB + GB;
    localparam int ENTRIES = PROC_CNT * PAGE_CNT;
    localparam int OCB = $clog2(FRAME_CNT + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    // configuration
    logic [4:0] shift_reg;
    logic [2:0] procs_reg;
    logic [6:0] pages_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 5'd12;
            procs_reg <= 3'd4;
            pages_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAGE_SHIFT: shift_reg <= cfg_data[4:0];
                CFG_PROCS:      procs_reg <= cfg_data[2:0];
                CFG_PAGES:      pages_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // captured request
    logic [1:0]           req_reg;
    logic [1:0]           pid_reg;
    logic [GB-1:0]        page_reg;
    logic [2:0]           acc_reg;
    logic [3:0]           fidx_reg;
    logic                 ok_reg;
    logic [ADDR_BITS-1:0] page_next;
    logic                 ok_next;

    always_comb
    begin
        page_next = (req_type == REQ_ALLOC) ? ADDR_BITS'(page_index)
                                            : (vaddr >> shift_reg);
        ok_next = (32'(pid) < 32'(procs_reg)) && (32'(pid) < PROC_CNT)
               && (page_next < ADDR_BITS'(pages_reg))
               && (page_next < ADDR_BITS'(PAGE_CNT))
               && (req_type != REQ_NONE)
               && (req_type != REQ_CLAIM || 32'(frame_index) < FRAME_CNT);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req_type;
            pid_reg  <= pid;
            page_reg <= page_next[GB-1:0];
            acc_reg  <= access_flags;
            fidx_reg <= frame_index;
            ok_reg   <= ok_next;
        end
    end

    logic [EB-1:0] e_idx;
    logic [FB-1:0] f_idx;
    assign e_idx = {pid_reg[PB-1:0], page_reg};
    assign f_idx = fidx_reg[FB-1:0];

    // entry memory with valid bits (cleared at reset)
    logic [6:0]    eflag_mem [ENTRIES];
    logic [FB-1:0] eframe_mem [ENTRIES];
    logic [ENTRIES-1:0] evld_reg;
    logic [6:0]    eflag_rd;
    logic [FB-1:0] eframe_rd;

    // frame table registers
    logic [FRAME_CNT-1:0]  focc_reg;
    logic [1:0]            fpid_reg [FRAME_CNT];
    logic [5:0]            fpage_reg [FRAME_CNT];
    logic [COUNT_BITS-1:0] frec_reg [FRAME_CNT];

    logic [COUNT_BITS-1:0] refc_reg, fltc_reg, disc_reg, wrc_reg;
    logic [OCB-1:0]        occ_reg;

    // read stage also reads the occupant's entry
    logic [EB-1:0] oe_idx;
    logic [6:0]    oflag_rd;
    logic          ovld;
    assign oe_idx = {fpid_reg[f_idx][PB-1:0], fpage_reg[f_idx][GB-1:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            eflag_rd  <= eflag_mem[e_idx];
            eframe_rd <= eframe_mem[e_idx];
            oflag_rd  <= eflag_mem[oe_idx];
        end
    end

    logic evld_e_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evld_e_reg <= 1'b0;
            ovld <= 1'b0;
        end
        else if (cmd.read)
        begin
            evld_e_reg <= evld_reg[e_idx];
            ovld <= evld_reg[oe_idx];
        end
    end

    logic [6:0]    fl, ofl;
    logic [FB-1:0] efr;
    assign fl  = evld_e_reg ? eflag_rd : 7'd0;
    assign efr = evld_e_reg ? eframe_rd : '0;
    assign ofl = ovld ? oflag_rd : 7'd0;

    // update decisions
    logic                  ew, ow, fw_own, fw_rec;
    logic [6:0]            ew_flags, ow_flags;
    logic                  ew_frame;
    logic [FB-1:0]         rec_f;
    logic [COUNT_BITS-1:0] rec_val, refc_n, fltc_n, disc_n, wrc_n;
    logic [OCB-1:0]        occ_n;
    logic [2:0]            st;
    logic [3:0]            fnum;
    logic                  ev, evd;
    logic [COUNT_BITS-1:0] stamp;
    logic                  same_e;

    always_comb
    begin
        ew = 1'b0; ow = 1'b0; fw_own = 1'b0; fw_rec = 1'b0; ew_frame = 1'b0;
        ew_flags = fl; ow_flags = ofl; rec_f = f_idx; rec_val = refc_reg;
        refc_n = refc_reg; fltc_n = fltc_reg; disc_n = disc_reg; wrc_n = wrc_reg;
        occ_n = occ_reg; st = ST_BAD_ARG; fnum = 4'd0; ev = 1'b0; evd = 1'b0;
        stamp = '0;
        same_e = (oe_idx == e_idx);
        if (ok_reg)
        begin
            case (req_reg)
                REQ_ALLOC:
                begin
                    ew = 1'b1;
                    ew_flags = {fl[6:4], 1'b1, acc_reg};
                    st = ST_DONE;
                end
                REQ_ACCESS:
                begin
                    if ((fl[2:0] & acc_reg) == 3'd0)
                        st = ST_DENIED;
                    else if (!fl[FL_ALLOC_B])
                        st = ST_NOT_ALLOC;
                    else
                    begin
                        refc_n = (refc_reg == CMAX) ? CMAX : refc_reg + 1'b1;
                        ew = 1'b1;
                        ew_flags = fl;
                        ew_flags[FL_REF_B] = 1'b1;
                        if (acc_reg[1]) ew_flags[FL_DIRTY_B] = 1'b1;
                        if (!fl[FL_VALID_B])
                        begin
                            fltc_n = (fltc_reg == CMAX) ? CMAX : fltc_reg + 1'b1;
                            st = ST_FAULT;
                        end
                        else
                        begin
                            fw_rec = 1'b1;
                            rec_f = efr;
                            rec_val = refc_n;
                            st = ST_HIT;
                            fnum = 4'(efr);
                            stamp = refc_n;
                        end
                    end
                end
                REQ_CLAIM:
                begin
                    stamp = frec_reg[f_idx];
                    if (focc_reg[f_idx])
                    begin
                        ev = 1'b1;
                        evd = ofl[FL_DIRTY_B];
                        if (evd)
                            wrc_n = (wrc_reg == CMAX) ? CMAX : wrc_reg + 1'b1;
                        else
                            disc_n = (disc_reg == CMAX) ? CMAX : disc_reg + 1'b1;
                        ow = 1'b1;
                        ow_flags = ofl & 7'b000_1111;
                        fw_rec = 1'b1;
                        stamp = refc_reg;
                    end
                    else if (32'(occ_reg) < FRAME_CNT)
                        occ_n = occ_reg + 1'b1;
                    fw_own = 1'b1;
                    ew = 1'b1;
                    ew_frame = 1'b1;
                    // new entry written after the occupant's update
                    ew_flags = (ow && same_e) ? ow_flags : fl;
                    ew_flags[FL_VALID_B] = 1'b1;
                    st = ST_DONE;
                    fnum = fidx_reg;
                end
                default: ;
            endcase
        end
    end

    // table writes
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            if (ow && !same_e)
                eflag_mem[oe_idx] <= ow_flags;
            if (ew)
                eflag_mem[e_idx] <= ew_flags;
            if (ew_frame)
                eframe_mem[e_idx] <= f_idx;
            else if (ew && !evld_e_reg)
                eframe_mem[e_idx] <= '0;
            if (ow && !same_e && !ovld)
                eframe_mem[oe_idx] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evld_reg <= '0;
            focc_reg <= '0;
            refc_reg <= '0;
            fltc_reg <= '0;
            disc_reg <= '0;
            wrc_reg <= '0;
            occ_reg <= '0;
            for (int i = 0; i < FRAME_CNT; i++)
            begin
                fpid_reg[i] <= '0;
                fpage_reg[i] <= '0;
                frec_reg[i] <= '0;
            end
        end
        else if (cmd.update)
        begin
            // an occupant entry has always been written, so only the new entry is marked
            if (ew) evld_reg[e_idx] <= 1'b1;
            if (fw_own)
            begin
                focc_reg[f_idx] <= 1'b1;
                fpid_reg[f_idx] <= pid_reg;
                fpage_reg[f_idx] <= page_reg;
            end
            if (fw_rec) frec_reg[rec_f] <= rec_val;
            refc_reg <= refc_n;
            fltc_reg <= fltc_n;
            disc_reg <= disc_n;
            wrc_reg <= wrc_n;
            occ_reg <= occ_n;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            status <= st;
            frame_number <= fnum;
            evicted <= ev;
            evicted_pid <= ev ? fpid_reg[f_idx] : 2'd0;
            victim_page <= ev ? fpage_reg[f_idx] : 6'd0;
            evicted_dirty <= evd;
            reference_total <= refc_n;
            fault_total <= fltc_n;
            discard_total <= disc_n;
            write_total <= wrc_n;
            free_frames <= 5'(FRAME_CNT - 32'(occ_n));
            frame_stamp <= stamp;
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(occ_reg) <= FRAME_CNT) else $error("occupied count overflow");
    a_ref_mono: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> refc_reg >= $past(refc_reg)) else $error("reference count fell");
    a_claim_occ: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && fw_own |=> focc_reg[$past(f_idx)]) else $error("claimed frame not marked");
endmodule

>>> sv/page_table_access_and_frame_claim_top.sv
// Top level: page tables with frame table, controller plus datapath
//  channel | direction | handshake
//  in      | input     | in_valid / in_stall
//  out     | output    | out_valid / out_stall
//  cfg     | input     | cfg_we, cfg_index, cfg_data
// Each request passes through capture, table read, then update into the result register.
// The entry memory read comes first, then the write-back of the new and the evicted entry.
// A new beat is taken in the cycle the result beat leaves.
// Reset is asynchronous, active low; the entry tables are cleared by valid bits.
// out_stall holds the result register; in_stall then stays high.
`timescale 1ns / 1ps
module page_table_access_and_frame_claim_top
    import ptfc_pkg::*;
#(
    parameter int ADDR_BITS = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [6:0]            cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            req_type,
    input  logic [1:0]            pid,
    input  logic [5:0]            page_index,
    input  logic [ADDR_BITS-1:0]  vaddr,
    input  logic [2:0]            access_flags,
    input  logic [3:0]            frame_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            status,
    output logic [3:0]            frame_number,
    output logic                  evicted,
    output logic [1:0]            evicted_pid,
    output logic [5:0]            victim_page,
    output logic                  evicted_dirty,
    output logic [COUNT_BITS-1:0] reference_total,
    output logic [COUNT_BITS-1:0] fault_total,
    output logic [COUNT_BITS-1:0] discard_total,
    output logic [COUNT_BITS-1:0] write_total,
    output logic [4:0]            free_frames,
    output logic [COUNT_BITS-1:0] frame_stamp
);
    ptfc_cmd_t cmd;

    ptfc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
    );

    ptfc_datapath #(
        .ADDR_BITS(ADDR_BITS), .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .req_type(req_type), .pid(pid), .page_index(page_index),
        .vaddr(vaddr), .access_flags(access_flags),
        .frame_index(frame_index),
        .status(status), .frame_number(frame_number), .evicted(evicted),
        .evicted_pid(evicted_pid), .victim_page(victim_page),
        .evicted_dirty(evicted_dirty), .reference_total(reference_total),
        .fault_total(fault_total), .discard_total(discard_total),
        .write_total(write_total), .free_frames(free_frames),
        .frame_stamp(frame_stamp)
    );
endmodule
